// ===== hw/rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the complex arithmetic unit.
// Used by complex_arith_unit_core and cau_div_step; depends on nothing.
package cau_pkg;

  // Quotient bits kept by the divider: enough to tell Q16.16 saturation apart.
  localparam int unsigned QW = 33;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_CMP = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_req_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               is_equal;
    logic               div_zero;
    logic               overflow;
  } cau_rsp_t;

endpackage

// ===== hw/rtl/cau_div_step.sv =====
`timescale 1ns / 1ps
// One restoring division step: settles quotient bit SH by compare and subtract.
// Depends on cau_pkg for the quotient width.
module cau_div_step #(
  parameter int unsigned RW = 80,
  parameter int unsigned SH = 0
) (
  input  logic                  en_i,
  input  logic [RW-1:0]         rem_i,
  input  logic [63:0]           den_i,
  input  logic [cau_pkg::QW-1:0] quo_i,
  output logic [RW-1:0]         rem_o,
  output logic [cau_pkg::QW-1:0] quo_o
);
  import cau_pkg::*;

  logic [RW-1:0] rem_sh;
  logic          ge;

  assign rem_sh = rem_i >> SH;
  assign ge     = en_i && (rem_sh >= RW'(den_i));

  always_comb begin
    rem_o = rem_i;
    quo_o = quo_i;
    if (ge) begin
      rem_o     = rem_i - (RW'(den_i) << SH);
      quo_o[SH] = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/complex_arith_unit_core.sv =====
`timescale 1ns / 1ps
// Complex add, subtract, multiply, divide and compare in signed fixed point.
// Depends on cau_pkg and cau_div_step.
//
//   port group   direction  handshake                 payload
//   request      in         req_valid_i / req_ready_o  req_i (cau_req_t)
//   response     out        rsp_valid_o / rsp_ready_i  rsp_o (cau_rsp_t)
//
// One request enters per cycle while req_ready_o is high; its response passes
// four stages of products, sums and magnitudes, 33 divider steps (one quotient
// bit each) and a saturating output register. The divider chain sets the depth.
// Reset clears the valid bits only. A two-entry output buffer lets the pipe
// run on while a response waits; the pipe holds only once both are full.
module complex_arith_unit_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  cau_pkg::cau_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output cau_pkg::cau_rsp_t rsp_o
);
  import cau_pkg::*;

  localparam int unsigned RW = 64 + FRAC_BITS;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic [63:0]        sq_r;
    logic [63:0]        sq_i;
    logic [32:0]        as_re;
    logic [32:0]        as_im;
    logic               eq;
  } s1_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [64:0] s_re;
    logic [64:0] s_im;
    logic [63:0] den;
    logic [32:0] as_re;
    logic [32:0] as_im;
    logic        eq;
  } s2_t;

  typedef struct packed {
    logic [2:0]  func;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
    logic        dz;
    logic        eq;
  } s3_t;

  typedef struct packed {
    logic          neg_re;
    logic          neg_im;
    logic          ovq_re;
    logic          ovq_im;
    logic          dvd;
    logic          is_equal;
    logic          div_zero;
    logic [QW-1:0] q_re;
    logic [QW-1:0] q_im;
    logic [RW-1:0] r_re;
    logic [RW-1:0] r_im;
    logic [63:0]   den;
  } dstg_t;

  logic  adv;
  logic  v1_q, v2_q, v3_q, v4_q;
  logic  [QW-1:0] dv_q;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  s3_t   s3_d, s3_q;
  dstg_t s4_d, s4_q;
  dstg_t d_d [QW];
  dstg_t d_q [QW];
  cau_rsp_t fin;
  cau_rsp_t out_q, skid_q;
  logic  out_v_q, skid_v_q;
  logic  last_fire;

  // Hold the whole pipe only when the output buffer is full.
  assign adv         = !skid_v_q;
  assign req_ready_o = adv;

  // Stage 1: products and short sums
  assign s1_d.func  = req_i.func;
  assign s1_d.p_rr  = req_i.a_re * req_i.b_re;
  assign s1_d.p_ii  = req_i.a_im * req_i.b_im;
  assign s1_d.p_ri  = req_i.a_re * req_i.b_im;
  assign s1_d.p_ir  = req_i.a_im * req_i.b_re;
  assign s1_d.sq_r  = req_i.b_re * req_i.b_re;
  assign s1_d.sq_i  = req_i.b_im * req_i.b_im;
  assign s1_d.as_re = (req_i.func == FUNC_SUB)
                    ? {req_i.a_re[31], req_i.a_re} - {req_i.b_re[31], req_i.b_re}
                    : {req_i.a_re[31], req_i.a_re} + {req_i.b_re[31], req_i.b_re};
  assign s1_d.as_im = (req_i.func == FUNC_SUB)
                    ? {req_i.a_im[31], req_i.a_im} - {req_i.b_im[31], req_i.b_im}
                    : {req_i.a_im[31], req_i.a_im} + {req_i.b_im[31], req_i.b_im};
  assign s1_d.eq    = (req_i.a_re == req_i.b_re) && (req_i.a_im == req_i.b_im);

  // Stage 2: exact cross sums and divisor
  always_comb begin
    s2_d       = '0;
    s2_d.func  = s1_q.func;
    s2_d.den   = s1_q.sq_r + s1_q.sq_i;
    s2_d.as_re = s1_q.as_re;
    s2_d.as_im = s1_q.as_im;
    s2_d.eq    = s1_q.eq;
    case (s1_q.func)
      FUNC_MUL: begin
        s2_d.s_re = {s1_q.p_rr[63], s1_q.p_rr} - {s1_q.p_ii[63], s1_q.p_ii};
        s2_d.s_im = {s1_q.p_ri[63], s1_q.p_ri} + {s1_q.p_ir[63], s1_q.p_ir};
      end
      FUNC_DIV: begin
        s2_d.s_re = {s1_q.p_rr[63], s1_q.p_rr} + {s1_q.p_ii[63], s1_q.p_ii};
        s2_d.s_im = {s1_q.p_ir[63], s1_q.p_ir} - {s1_q.p_ri[63], s1_q.p_ri};
      end
      default: begin
        s2_d.s_re = '0;
        s2_d.s_im = '0;
      end
    endcase
  end

  // Stage 3: sign and magnitude
  logic [64:0] abs_re, abs_im;
  logic [32:0] sabs_re, sabs_im;

  assign abs_re  = s2_q.s_re[64] ? 65'd0 - s2_q.s_re : s2_q.s_re;
  assign abs_im  = s2_q.s_im[64] ? 65'd0 - s2_q.s_im : s2_q.s_im;
  assign sabs_re = s2_q.as_re[32] ? 33'd0 - s2_q.as_re : s2_q.as_re;
  assign sabs_im = s2_q.as_im[32] ? 33'd0 - s2_q.as_im : s2_q.as_im;

  always_comb begin
    s3_d      = '0;
    s3_d.func = s2_q.func;
    s3_d.den  = s2_q.den;
    s3_d.dz   = (s2_q.den == 64'd0);
    s3_d.eq   = s2_q.eq;
    case (s2_q.func)
      FUNC_ADD, FUNC_SUB: begin
        s3_d.neg_re = s2_q.as_re[32];
        s3_d.neg_im = s2_q.as_im[32];
        s3_d.mag_re = 64'(sabs_re);
        s3_d.mag_im = 64'(sabs_im);
      end
      FUNC_MUL, FUNC_DIV: begin
        s3_d.neg_re = s2_q.s_re[64];
        s3_d.neg_im = s2_q.s_im[64];
        s3_d.mag_re = abs_re[63:0];
        s3_d.mag_im = abs_im[63:0];
      end
      default: ;
    endcase
  end

  // Stage 4: scale, early overflow, divider set-up
  logic [63:0] msh_re, msh_im;
  logic [RW-1:0] num_re, num_im;

  assign msh_re = s3_q.mag_re >> FRAC_BITS;
  assign msh_im = s3_q.mag_im >> FRAC_BITS;
  assign num_re = RW'(s3_q.mag_re) << FRAC_BITS;
  assign num_im = RW'(s3_q.mag_im) << FRAC_BITS;

  always_comb begin
    s4_d          = '0;
    s4_d.den      = s3_q.den;
    s4_d.is_equal = (s3_q.func == FUNC_CMP) && s3_q.eq;
    s4_d.div_zero = (s3_q.func == FUNC_DIV) && s3_q.dz;
    case (s3_q.func)
      FUNC_ADD, FUNC_SUB: begin
        s4_d.neg_re = s3_q.neg_re;
        s4_d.neg_im = s3_q.neg_im;
        s4_d.q_re   = s3_q.mag_re[QW-1:0];
        s4_d.q_im   = s3_q.mag_im[QW-1:0];
      end
      FUNC_MUL: begin
        s4_d.neg_re = s3_q.neg_re;
        s4_d.neg_im = s3_q.neg_im;
        s4_d.q_re   = msh_re[QW-1:0];
        s4_d.q_im   = msh_im[QW-1:0];
        s4_d.ovq_re = |msh_re[63:QW];
        s4_d.ovq_im = |msh_im[63:QW];
      end
      FUNC_DIV: begin
        if (!s3_q.dz) begin
          s4_d.dvd    = 1'b1;
          s4_d.neg_re = s3_q.neg_re;
          s4_d.neg_im = s3_q.neg_im;
          s4_d.r_re   = num_re;
          s4_d.r_im   = num_im;
          // quotient of 2^QW or more saturates whatever its low bits
          s4_d.ovq_re = (num_re >> QW) >= RW'(s3_q.den);
          s4_d.ovq_im = (num_im >> QW) >= RW'(s3_q.den);
        end
      end
      default: ;
    endcase
  end

  // Divider: one quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    dstg_t din;
    logic  vin;

    assign din = (k == 0) ? s4_q : d_q[(k == 0) ? 0 : k - 1];
    assign vin = (k == 0) ? v4_q : dv_q[(k == 0) ? 0 : k - 1];

    cau_div_step #(.RW(RW), .SH(QW - 1 - k)) u_step_re (
      .en_i  (din.dvd && !din.ovq_re),
      .rem_i (din.r_re),
      .den_i (din.den),
      .quo_i (din.q_re),
      .rem_o (d_d[k].r_re),
      .quo_o (d_d[k].q_re)
    );

    cau_div_step #(.RW(RW), .SH(QW - 1 - k)) u_step_im (
      .en_i  (din.dvd && !din.ovq_im),
      .rem_i (din.r_im),
      .den_i (din.den),
      .quo_i (din.q_im),
      .rem_o (d_d[k].r_im),
      .quo_o (d_d[k].q_im)
    );

    assign d_d[k].neg_re   = din.neg_re;
    assign d_d[k].neg_im   = din.neg_im;
    assign d_d[k].ovq_re   = din.ovq_re;
    assign d_d[k].ovq_im   = din.ovq_im;
    assign d_d[k].dvd      = din.dvd;
    assign d_d[k].is_equal = din.is_equal;
    assign d_d[k].div_zero = din.div_zero;
    assign d_d[k].den      = din.den;

    always_ff @(posedge clk_i) begin
      if (adv && vin) begin
        d_q[k] <= d_d[k];
      end
    end
  end

  // Saturate one part to the signed 32-bit range; top bit flags overflow
  function automatic logic [32:0] sat_part(logic neg, logic ovq, logic [QW-1:0] q);
    logic        big;
    logic [31:0] res;
    big = ovq || (neg ? (q > QW'(33'h0_8000_0000)) : (q > QW'(33'h0_7FFF_FFFF)));
    if (big) begin
      res = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = neg ? 32'd0 - q[31:0] : q[31:0];
    end
    return {big, res};
  endfunction

  logic [32:0] sat_re, sat_im;

  assign sat_re       = sat_part(d_q[QW-1].neg_re, d_q[QW-1].ovq_re, d_q[QW-1].q_re);
  assign sat_im       = sat_part(d_q[QW-1].neg_im, d_q[QW-1].ovq_im, d_q[QW-1].q_im);
  assign fin.res_re   = sat_re[31:0];
  assign fin.res_im   = sat_im[31:0];
  assign fin.is_equal = d_q[QW-1].is_equal;
  assign fin.div_zero = d_q[QW-1].div_zero;
  assign fin.overflow = sat_re[32] | sat_im[32];
  assign last_fire    = dv_q[QW-1] && adv;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      dv_q <= '0;
    end else if (adv) begin
      v1_q <= req_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      dv_q <= {dv_q[QW-2:0], v4_q};
    end
  end

  // Front payload registers
  always_ff @(posedge clk_i) begin
    if (adv && req_valid_i) s1_q <= s1_d;
    if (adv && v1_q)        s2_q <= s2_d;
    if (adv && v2_q)        s3_q <= s3_d;
    if (adv && v3_q)        s4_q <= s4_d;
  end

  // Output register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || rsp_ready_i) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= last_fire;
      end
    end else if (last_fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || rsp_ready_i) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (last_fire) begin
        out_q <= fin;
      end
    end else if (last_fire) begin
      skid_q <= fin;
    end
  end

  assign rsp_valid_o = out_v_q;
  assign rsp_o       = out_q;

  // Checks
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.div_zero |->
      rsp_o.res_re == 32'sd0 && rsp_o.res_im == 32'sd0 && !rsp_o.overflow)
    else $error("divide by zero gave a nonzero result or overflow");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.is_equal && (rsp_o.div_zero || rsp_o.overflow)))
    else $error("compare flag raised together with another flag");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.overflow |->
      rsp_o.res_re == 32'sh7FFF_FFFF || rsp_o.res_re == 32'sh8000_0000 ||
      rsp_o.res_im == 32'sh7FFF_FFFF || rsp_o.res_im == 32'sh8000_0000)
    else $error("overflow without a saturated part");

  a_skid_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !rsp_ready_i))
    else $error("skid entry filled while the output was free");

endmodule
